### rtl/bms_pkg.sv
package bms_pkg;

  // Sizing of the slave
  localparam int MEM_WORDS        = 65536;
  localparam int READ_QUEUE_DEPTH = 8;
  localparam int BEAT_WORDS       = 1;
  localparam int BYTES_PER_WORD   = 8;

  localparam int DATA_W  = BYTES_PER_WORD * 8;
  localparam int MEM_AW  = $clog2(MEM_WORDS);
  localparam int BYTE_SH = $clog2(BYTES_PER_WORD);
  localparam int RQ_PW   = (READ_QUEUE_DEPTH > 1) ? $clog2(READ_QUEUE_DEPTH) : 1;
  localparam int RQ_CW   = $clog2(READ_QUEUE_DEPTH + 1);

  localparam logic [31:0]      BEAT_STRIDE = 32'(BYTES_PER_WORD * BEAT_WORDS);
  localparam logic [RQ_CW-1:0] RQ_FULL     = RQ_CW'(READ_QUEUE_DEPTH);
  localparam logic [RQ_PW-1:0] RQ_LAST     = RQ_PW'(READ_QUEUE_DEPTH - 1);

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_RESP
  } bms_state_t;

  // One cycle's worth of requests, as handed from front to back
  typedef struct packed {
    logic                      rq_valid;
    logic [7:0]                rq_len;
    logic [7:0]                rq_tag;
    logic [31:0]               rq_addr;
    logic                      wa_valid;
    logic [31:0]               wa_addr;
    logic                      wb_valid;
    logic [DATA_W-1:0]         wb_data;
    logic [BYTES_PER_WORD-1:0] wb_be;
    logic                      ready;
  } bms_cmd_t;

  // Head of the command queue seen by the back end
  typedef struct packed {
    logic     valid;
    bms_cmd_t cmd;
  } bms_fq_t;

  // Backing store access: one write and one read port
  typedef struct packed {
    logic                      we;
    logic [BYTES_PER_WORD-1:0] be;
    logic [MEM_AW-1:0]         waddr;
    logic [DATA_W-1:0]         wdata;
    logic                      re;
    logic [MEM_AW-1:0]         raddr;
  } bms_mem_req_t;

  // Byte address to word index, low bits ignored, wraps over the store
  function automatic logic [MEM_AW-1:0] word_idx(input logic [31:0] addr);
    return addr[BYTE_SH +: MEM_AW];
  endfunction

  // Queue pointer increment with wrap at the depth
  function automatic logic [RQ_PW-1:0] rq_inc(input logic [RQ_PW-1:0] ptr);
    return (ptr == RQ_LAST) ? '0 : ptr + 1'b1;
  endfunction

endpackage

### rtl/bms_mem.sv
module bms_mem import bms_pkg::*; (
  input  logic              clk,
  input  bms_mem_req_t      req,
  output logic [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem_r [MEM_WORDS];

  // Byte-masked write
  always_ff @(posedge clk) begin
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      if (req.we && req.be[i]) begin
        mem_r[req.waddr][i*8 +: 8] <= req.wdata[i*8 +: 8];
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

endmodule

### rtl/bms_front.sv
module bms_front import bms_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_read_request_valid,
  input  logic [7:0]                in_read_request_length,
  input  logic [7:0]                in_read_request_tag,
  input  logic [31:0]               in_read_request_address,
  input  logic                      in_write_request_valid,
  input  logic [31:0]               in_write_request_address,
  input  logic                      in_write_beat_valid,
  input  logic [DATA_W-1:0]         in_write_beat_data,
  input  logic [BYTES_PER_WORD-1:0] in_write_byte_enables,
  input  logic                      in_read_beat_ready,
  input  logic                      pop,
  output bms_fq_t                   fq
);

  bms_cmd_t   buf_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  bms_cmd_t   cmd_in;

  // Pack the incoming word into a command
  always_comb begin
    cmd_in.rq_valid = in_read_request_valid;
    cmd_in.rq_len   = in_read_request_length;
    cmd_in.rq_tag   = in_read_request_tag;
    cmd_in.rq_addr  = in_read_request_address;
    cmd_in.wa_valid = in_write_request_valid;
    cmd_in.wa_addr  = in_write_request_address;
    cmd_in.wb_valid = in_write_beat_valid;
    cmd_in.wb_data  = in_write_beat_data;
    cmd_in.wb_be    = in_write_beat_valid ? in_write_byte_enables : '0;
    cmd_in.ready    = in_read_beat_ready;
  end

  // Two-entry command queue
  assign busy     = (cnt_r == 2'd2);
  assign accept   = start && !busy;
  assign fq.valid = (cnt_r != 2'd0);
  assign fq.cmd   = buf_r[rp_r];

  always_comb begin
    wp_nxt  = accept ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (accept && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!accept && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[wp_r] <= cmd_in;
    end
  end

endmodule

### rtl/bms_back.sv
module bms_back import bms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bms_fq_t           fq,
  output logic              pop,
  output bms_mem_req_t      mreq,
  input  logic [DATA_W-1:0] mem_rdata,
  output logic              out_strobe,
  output logic              out_read_beat_valid,
  output logic [7:0]        out_read_beat_tag,
  output logic [DATA_W-1:0] out_read_beat_data,
  output logic              out_request_dropped
);

  bms_state_t       state_r, state_nxt;
  bms_cmd_t         cmd_r, cmd_nxt;
  logic [31:0]      wa_r, wa_nxt, wa_cur;
  logic [RQ_PW-1:0] head_r, head_nxt;
  logic [RQ_PW-1:0] tail_r, tail_nxt;
  logic [RQ_CW-1:0] count_r, count_nxt;
  logic             beat_valid_r, beat_valid_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic             dropped_r, dropped_nxt;

  logic [31:0]      q_addr_r [READ_QUEUE_DEPTH];
  logic [7:0]       q_rem_r  [READ_QUEUE_DEPTH];
  logic [7:0]       q_tag_r  [READ_QUEUE_DEPTH];

  logic             full, nonempty, enq, adv, retire;

  assign full     = (count_r == RQ_FULL);
  assign nonempty = (count_r != '0);
  assign wa_cur   = cmd_r.wa_valid ? cmd_r.wa_addr : wa_r;

  // Next state
  always_comb begin
    unique case (state_r)
      ST_IDLE:  state_nxt = fq.valid ? ST_WRITE : ST_IDLE;
      ST_WRITE: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_RESP;
      ST_RESP:  state_nxt = fq.valid ? ST_WRITE : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop        = 1'b0;
    out_strobe = 1'b0;
    unique case (state_r)
      ST_IDLE:  pop = fq.valid;
      ST_WRITE: pop = 1'b0;
      ST_READ:  pop = 1'b0;
      ST_RESP: begin
        pop        = fq.valid;
        out_strobe = 1'b1;
      end
      default:  pop = 1'b0;
    endcase
  end

  // Datapath: enqueue and write in one step, front burst read in the next
  always_comb begin
    cmd_nxt        = pop ? fq.cmd : cmd_r;
    wa_nxt         = wa_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    beat_valid_nxt = beat_valid_r;
    tag_nxt        = tag_r;
    dropped_nxt    = dropped_r;
    enq            = 1'b0;
    adv            = 1'b0;
    retire         = 1'b0;
    mreq           = '0;
    case (state_r)
      ST_WRITE: begin
        dropped_nxt = cmd_r.rq_valid && full;
        enq         = cmd_r.rq_valid && !full;
        wa_nxt      = wa_cur;
        if (enq) begin
          tail_nxt  = rq_inc(tail_r);
          count_nxt = count_r + 1'b1;
        end
        if (cmd_r.wb_valid) begin
          mreq.we    = 1'b1;
          mreq.be    = cmd_r.wb_be;
          mreq.waddr = word_idx(wa_cur);
          mreq.wdata = cmd_r.wb_data;
          wa_nxt     = wa_cur + BEAT_STRIDE;
        end
      end
      ST_READ: begin
        beat_valid_nxt = nonempty;
        tag_nxt        = nonempty ? q_tag_r[head_r] : 8'd0;
        mreq.re        = nonempty;
        mreq.raddr     = word_idx(q_addr_r[head_r]);
        adv            = nonempty && cmd_r.ready;
        retire         = adv && (q_rem_r[head_r] == 8'd0);
        if (retire) begin
          head_nxt  = rq_inc(head_r);
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wa_r         <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      beat_valid_r <= 1'b0;
      dropped_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wa_r         <= wa_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      beat_valid_r <= beat_valid_nxt;
      dropped_r    <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    tag_r <= tag_nxt;
  end

  // Read burst queue: fill at tail, step the front burst at head
  always_ff @(posedge clk) begin
    if (enq) begin
      q_addr_r[tail_r] <= cmd_r.rq_addr;
      q_rem_r[tail_r]  <= cmd_r.rq_len;
      q_tag_r[tail_r]  <= cmd_r.rq_tag;
    end
    if (adv) begin
      q_addr_r[head_r] <= q_addr_r[head_r] + BEAT_STRIDE;
      if (q_rem_r[head_r] != 8'd0) begin
        q_rem_r[head_r] <= q_rem_r[head_r] - 8'd1;
      end
    end
  end

  // Result word
  assign out_read_beat_valid = beat_valid_r;
  assign out_read_beat_tag   = tag_r;
  assign out_read_beat_data  = beat_valid_r ? mem_rdata : '0;
  assign out_request_dropped = dropped_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RQ_FULL)
    else $error("read queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && cmd_r.rq_valid && full) |=> dropped_r && count_r == RQ_FULL)
    else $error("full queue request not dropped");

  a_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && cmd_r.wb_valid) |=> wa_r == $past(wa_cur) + BEAT_STRIDE)
    else $error("write address did not advance by one beat");

  a_port_split: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.we && mreq.re))
    else $error("store written and read in the same cycle");

endmodule

### rtl/burst_memory_slave_top.sv
// Channel   Handshake                 Fields
// input     start in, busy out        in_read_request_*, in_write_*, in_read_beat_ready
// result    out_strobe out            out_read_beat_valid/tag/data, out_request_dropped
//
// In the back end each word goes through the write, read and result states (queue and
// write the store, read the front burst's beat, present the result), set by the store's
// write-then-read order. A word accepted into an idle block is popped from the queue first.
// Two words can wait in the command queue; busy rises when it is full.
// Reset is synchronous; control state clears, store contents are undefined until written.
// The result is shown for one cycle on out_strobe; the receiver cannot stall it.
module burst_memory_slave_top import bms_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_read_request_valid,
  input  logic [7:0]                in_read_request_length,
  input  logic [7:0]                in_read_request_tag,
  input  logic [31:0]               in_read_request_address,
  input  logic                      in_write_request_valid,
  input  logic [31:0]               in_write_request_address,
  input  logic                      in_write_beat_valid,
  input  logic [DATA_W-1:0]         in_write_beat_data,
  input  logic [BYTES_PER_WORD-1:0] in_write_byte_enables,
  input  logic                      in_read_beat_ready,
  output logic                      out_strobe,
  output logic                      out_read_beat_valid,
  output logic [7:0]                out_read_beat_tag,
  output logic [DATA_W-1:0]         out_read_beat_data,
  output logic                      out_request_dropped
);

  bms_fq_t           fq;
  logic              pop;
  bms_mem_req_t      mreq;
  logic [DATA_W-1:0] mem_rdata;

  // Front: accept and queue commands
  bms_front u_front (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_read_request_valid    (in_read_request_valid),
    .in_read_request_length   (in_read_request_length),
    .in_read_request_tag      (in_read_request_tag),
    .in_read_request_address  (in_read_request_address),
    .in_write_request_valid   (in_write_request_valid),
    .in_write_request_address (in_write_request_address),
    .in_write_beat_valid      (in_write_beat_valid),
    .in_write_beat_data       (in_write_beat_data),
    .in_write_byte_enables    (in_write_byte_enables),
    .in_read_beat_ready       (in_read_beat_ready),
    .pop                      (pop),
    .fq                       (fq)
  );

  // Back: burst queue and store sequencing
  bms_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fq                  (fq),
    .pop                 (pop),
    .mreq                (mreq),
    .mem_rdata           (mem_rdata),
    .out_strobe          (out_strobe),
    .out_read_beat_valid (out_read_beat_valid),
    .out_read_beat_tag   (out_read_beat_tag),
    .out_read_beat_data  (out_read_beat_data),
    .out_request_dropped (out_request_dropped)
  );

  // Backing store
  bms_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rdata_r (mem_rdata)
  );

endmodule
